/* design/plzm_pkg.sv */
// Package for the piecewise linear zoom map unit.
// Holds field widths, register indexes, reset constants and region codes.
package plzm_pkg;
  localparam int POS_W = 15;
  localparam int RAD_W = 20;
  localparam int ENTRY_W = 35;
  localparam int CNT_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int MAX_ENTRIES = 4;
  localparam int DEF_TABLE_ENTRIES = 4;
  localparam int DEF_RADIUS_FRAC_BITS = 8;
  localparam int KEY_W = RAD_W;
  localparam int PROD_W = KEY_W + KEY_W;
  localparam int DIV_STEPS = PROD_W;

  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY3 = 3'd4;

  localparam logic [CNT_W-1:0] RESET_COUNT = 3'd2;
  localparam logic [POS_W-1:0] RESET_POS_HI = 15'd16384;
  localparam int RESET_RAD_HI = 2000;
  localparam int RESET_RAD_LO = 1;

  localparam logic [1:0] REGION_INTERP = 2'd0;
  localparam logic [1:0] REGION_CLAMP = 2'd1;
  localparam logic [1:0] REGION_ZERO = 2'd2;
endpackage

/* design/piecewise_linear_zoom_map_unit.sv */
// Piecewise linear zoom map unit: position <-> radius through a breakpoint table.
// Depends on plzm_pkg; one-result-per-transfer pipeline with a restoring divider.
//
// Channel   Dir   Handshake              Payload
// in_       in    in_valid/in_ready      func, zoom_position, radius
// out_      out   out_valid/out_ready    radius_out, position_out, region
// cfg_      in    cfg_we                 cfg_index, cfg_wdata
//
// One transfer per cycle while the output is not stalled; a result passes through
// capture, search, multiply, 40 radix-2 divider stages (one quotient bit per
// stage over the 40-bit product) and the output register.
// Reset loads the default table and empties the pipeline.
// A stall at the output holds every stage; in_ready is high unless a result waits.
module piecewise_linear_zoom_map_unit #(
  parameter int TABLE_ENTRIES = plzm_pkg::DEF_TABLE_ENTRIES,
  parameter int RADIUS_FRAC_BITS = plzm_pkg::DEF_RADIUS_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_func,
  input  logic [plzm_pkg::POS_W-1:0]     in_zoom_position,
  input  logic [plzm_pkg::RAD_W-1:0]     in_radius,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [plzm_pkg::RAD_W-1:0]     out_radius_out,
  output logic [plzm_pkg::POS_W-1:0]     out_position_out,
  output logic [1:0]                     out_region,
  input  logic                           cfg_we,
  input  logic [plzm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [plzm_pkg::ENTRY_W-1:0]   cfg_wdata
);
  import plzm_pkg::*;

  localparam logic [RAD_W-1:0] RAD_LO_RST = RAD_W'(RESET_RAD_LO << RADIUS_FRAC_BITS);
  localparam logic [RAD_W-1:0] RAD_HI_RST = RAD_W'(RESET_RAD_HI << RADIUS_FRAC_BITS);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(TABLE_ENTRIES);
  localparam int NS = DIV_STEPS;

  typedef struct packed {
    logic             func;
    logic [1:0]       region;
    logic [KEY_W-1:0] v0;
    logic             neg;
  } meta_t;

  logic [CNT_W-1:0]   count_r;
  logic [POS_W-1:0]   pos_r [MAX_ENTRIES];
  logic [RAD_W-1:0]   rad_r [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= RESET_COUNT;
      pos_r[0] <= '0;
      rad_r[0] <= RAD_LO_RST;
      pos_r[1] <= RESET_POS_HI;
      rad_r[1] <= RAD_HI_RST;
      pos_r[2] <= '0;
      rad_r[2] <= '0;
      pos_r[3] <= '0;
      rad_r[3] <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_COUNT) begin
        count_r <= cfg_wdata[CNT_W-1:0];
      end else if (cfg_index >= REG_ENTRY0 && cfg_index <= REG_ENTRY3) begin
        pos_r[2'(cfg_index - REG_ENTRY0)] <= cfg_wdata[ENTRY_W-1:RAD_W];
        rad_r[2'(cfg_index - REG_ENTRY0)] <= cfg_wdata[RAD_W-1:0];
      end
    end
  end

  logic adv;
  assign adv = out_ready || !out_valid;
  assign in_ready = adv;

  // stage 1: capture input, pick keys/values
  logic             s1_v_r;
  logic             s1_func_r;
  logic [KEY_W-1:0] s1_x_r;
  logic [KEY_W-1:0] s1_k_r [MAX_ENTRIES];
  logic [KEY_W-1:0] s1_val_r [MAX_ENTRIES];
  logic [CNT_W-1:0] s1_cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  always_comb begin
    cnt_nxt = count_r;
    if (cnt_nxt == '0) cnt_nxt = CNT_W'(1);
    if (cnt_nxt > MAX_CNT) cnt_nxt = MAX_CNT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_func_r <= in_func;
      s1_x_r <= in_func ? in_radius : KEY_W'(in_zoom_position);
      s1_cnt_r <= cnt_nxt;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        s1_k_r[i] <= in_func ? rad_r[i] : KEY_W'(pos_r[i]);
        s1_val_r[i] <= in_func ? KEY_W'(pos_r[i]) : rad_r[i];
      end
    end
  end

  // stage 2: search and segment setup
  logic             s2_v_r;
  meta_t            s2_meta_r;
  logic [KEY_W-1:0] s2_off_r;
  logic [KEY_W-1:0] s2_dv_r;
  logic [KEY_W-1:0] s2_w_r;
  logic [2:0]       n_c;
  meta_t            meta_c;
  logic [KEY_W-1:0] off_c, dv_c, w_c, k0_c, k1_c, v1_c;

  always_comb begin
    n_c = {1'b0, s1_cnt_r[1:0]};
    n_c = 3'(s1_cnt_r);
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (3'(i) < s1_cnt_r && s1_k_r[i] > s1_x_r) n_c = 3'(i);
    end
    meta_c.func = s1_func_r;
    meta_c.region = REGION_INTERP;
    meta_c.neg = 1'b0;
    meta_c.v0 = s1_val_r[0];
    k0_c = '0;
    k1_c = '0;
    v1_c = '0;
    off_c = '0;
    dv_c = '0;
    w_c = KEY_W'(1);
    if (n_c == 3'(s1_cnt_r)) begin
      meta_c.region = REGION_CLAMP;
      meta_c.v0 = s1_val_r[2'(s1_cnt_r - CNT_W'(1))];
    end else if (n_c == '0) begin
      meta_c.region = REGION_CLAMP;
    end else begin
      k0_c = s1_k_r[2'(n_c - 3'd1)];
      k1_c = s1_k_r[2'(n_c)];
      meta_c.v0 = s1_val_r[2'(n_c - 3'd1)];
      v1_c = s1_val_r[2'(n_c)];
      if (k1_c <= k0_c) begin
        meta_c.region = REGION_ZERO;
      end else begin
        w_c = k1_c - k0_c;
        off_c = s1_x_r - k0_c;
        meta_c.neg = v1_c < meta_c.v0;
        dv_c = meta_c.neg ? meta_c.v0 - v1_c : v1_c - meta_c.v0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_meta_r <= meta_c;
      s2_off_r <= off_c;
      s2_dv_r <= dv_c;
      s2_w_r <= w_c;
    end
  end

  // stage 3: multiply
  logic              s3_v_r;
  meta_t             s3_meta_r;
  logic [PROD_W-1:0] s3_prod_r;
  logic [KEY_W-1:0]  s3_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_meta_r <= s2_meta_r;
      s3_prod_r <= s2_off_r * s2_dv_r;
      s3_w_r <= s2_w_r;
    end
  end

  // divider: one quotient bit per stage
  logic              d_v_r   [NS+1];
  meta_t             d_meta_r[NS+1];
  logic [PROD_W-1:0] d_num_r [NS+1];
  logic [KEY_W:0]    d_rem_r [NS+1];
  logic [KEY_W-1:0]  d_w_r   [NS+1];

  always_comb begin
    d_v_r[0] = s3_v_r;
    d_meta_r[0] = s3_meta_r;
    d_num_r[0] = s3_prod_r;
    d_rem_r[0] = '0;
    d_w_r[0] = s3_w_r;
  end

  for (genvar g = 0; g < NS; g++) begin : g_div
    logic [KEY_W+1:0] sh;
    logic [KEY_W+1:0] diff;
    assign sh = {d_rem_r[g], d_num_r[g][PROD_W-1]};
    assign diff = sh - {2'b00, d_w_r[g]};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d_v_r[g+1] <= 1'b0;
      end else if (adv) begin
        d_v_r[g+1] <= d_v_r[g];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        d_meta_r[g+1] <= d_meta_r[g];
        d_w_r[g+1] <= d_w_r[g];
        if (!diff[KEY_W+1]) begin
          d_rem_r[g+1] <= diff[KEY_W:0];
          d_num_r[g+1] <= {d_num_r[g][PROD_W-2:0], 1'b1};
        end else begin
          d_rem_r[g+1] <= sh[KEY_W:0];
          d_num_r[g+1] <= {d_num_r[g][PROD_W-2:0], 1'b0};
        end
      end
    end
  end

  // output stage
  logic [KEY_W-1:0] res_c;
  logic [KEY_W-1:0] q_c;
  meta_t            mo;
  assign mo = d_meta_r[NS];
  assign q_c = d_num_r[NS][KEY_W-1:0];
  always_comb begin
    res_c = mo.v0;
    if (mo.region == REGION_INTERP) begin
      res_c = mo.neg ? mo.v0 - q_c : mo.v0 + q_c;
    end
  end

  logic             out_valid_r;
  logic [RAD_W-1:0] radius_out_r;
  logic [POS_W-1:0] position_out_r;
  logic [1:0]       region_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= d_v_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      radius_out_r <= mo.func ? '0 : res_c;
      position_out_r <= mo.func ? res_c[POS_W-1:0] : '0;
      region_r <= mo.region;
    end
  end

  assign out_valid = out_valid_r;
  assign out_radius_out = radius_out_r;
  assign out_position_out = position_out_r;
  assign out_region = region_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_radius_out) && $stable(out_position_out))
    else $error("result changed during stall");
  a_region_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_region != 2'd3)
    else $error("bad region code");
  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_radius_out == '0 || out_position_out == '0))
    else $error("both result fields nonzero");
endmodule
